// ===== src/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    localparam int QueueDepth = 4;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_NOTSTR = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_SBS  = 3'd4,
        MODE_SU   = 3'd5,
        MODE_HEX2 = 3'd6
    } mode_t;

    // Result bytes of one source byte; bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic [1:0]      kind;
    } pkt_t;

endpackage
`default_nettype wire

// ===== src/jsu_front.sv =====
// Front end: takes source bytes, tracks string and escape state, builds result packets.
`default_nettype none
module jsu_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    text_byte,
    input  wire logic          q_full,
    output logic               push,
    output jsu_pkg::pkt_t      pkt
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     digit_count_reg, digit_count_next;
    logic [15:0]    code_accum_reg, code_accum_next;
    logic [9:0]     high_half_reg, high_half_next;
    logic           digit_bad_reg, digit_bad_next;

    logic           accept;
    logic [3:0]     hex_val;
    logic           hex_ok;
    logic [15:0]    acc_new;
    logic           bad_new;
    logic           done;
    logic [15:0]    uc1;
    logic [20:0]    cp2;
    jsu_pkg::pkt_t  utf1;
    jsu_pkg::pkt_t  utf2;

    function automatic jsu_pkg::pkt_t utf8_encode(input logic [20:0] cp);
        jsu_pkg::pkt_t r;
        r.bytes = '0;
        r.kind  = jsu_pkg::KIND_DATA;
        if (cp < 21'h80) begin
            r.bytes[0] = {1'b0, cp[6:0]};
            r.count    = 3'd1;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

    function automatic jsu_pkg::pkt_t single(input logic [7:0] b, input logic [1:0] k);
        jsu_pkg::pkt_t r;
        r.bytes    = '0;
        r.bytes[0] = b;
        r.count    = 3'd1;
        r.kind     = k;
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        case (b)
            jsu_pkg::CH_B: r = 8'h08;
            jsu_pkg::CH_F: r = 8'h0C;
            jsu_pkg::CH_N: r = 8'h0A;
            jsu_pkg::CH_R: r = 8'h0D;
            jsu_pkg::CH_T: r = 8'h09;
            default:       r = b;
        endcase
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
            hex_val = text_byte[3:0];
        end else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
                     (text_byte >= 8'h41 && text_byte <= 8'h46)) begin
            hex_val = text_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_new = {code_accum_reg[11:0], hex_val};
    assign bad_new = digit_bad_reg || !hex_ok;
    assign done    = (digit_count_reg == 2'd3);
    assign uc1     = bad_new ? 16'd0 : acc_new;
    assign cp2     = 21'h10000 + {1'b0, high_half_reg, acc_new[9:0]};
    assign utf1    = utf8_encode({5'd0, uc1});
    assign utf2    = utf8_encode(cp2);

    always_comb
    begin
        mode_next        = mode_reg;
        digit_count_next = digit_count_reg;
        code_accum_next  = code_accum_reg;
        high_half_next   = high_half_reg;
        digit_bad_next   = digit_bad_reg;
        unique case (mode_reg)
            jsu_pkg::MODE_WAIT:
            begin
                if (text_byte == jsu_pkg::CH_QUOTE) mode_next = jsu_pkg::MODE_STR;
            end
            jsu_pkg::MODE_STR, jsu_pkg::MODE_SBS:
            begin
                if (text_byte == jsu_pkg::CH_QUOTE || text_byte == jsu_pkg::CH_NUL) begin
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (text_byte == jsu_pkg::CH_BSL) begin
                    mode_next = (mode_reg == jsu_pkg::MODE_SBS) ? jsu_pkg::MODE_SU
                                                               : jsu_pkg::MODE_ESC;
                end else begin
                    mode_next = jsu_pkg::MODE_STR;
                end
            end
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_SU:
            begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (text_byte == jsu_pkg::CH_U) begin
                    mode_next        = (mode_reg == jsu_pkg::MODE_SU) ? jsu_pkg::MODE_HEX2
                                                                     : jsu_pkg::MODE_HEX1;
                    digit_count_next = 2'd0;
                    code_accum_next  = 16'd0;
                    digit_bad_next   = 1'b0;
                end else begin
                    mode_next = jsu_pkg::MODE_STR;
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2:
            begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    mode_next = jsu_pkg::MODE_WAIT;
                end else begin
                    code_accum_next = acc_new;
                    digit_bad_next  = bad_new;
                    if (!done) begin
                        digit_count_next = digit_count_reg + 2'd1;
                    end else if (mode_reg == jsu_pkg::MODE_HEX1 &&
                                 uc1[15:10] == 6'b110110) begin
                        mode_next      = jsu_pkg::MODE_SBS;
                        high_half_next = uc1[9:0];
                    end else begin
                        mode_next = jsu_pkg::MODE_STR;
                    end
                end
            end
            default:
            begin
                mode_next = jsu_pkg::MODE_WAIT;
            end
        endcase
    end

    always_comb
    begin
        pkt = single(8'h00, jsu_pkg::KIND_DATA);
        pkt.count = 3'd0;
        unique case (mode_reg)
            jsu_pkg::MODE_WAIT:
            begin
                if (text_byte != jsu_pkg::CH_QUOTE) pkt = single(8'h00, jsu_pkg::KIND_NOTSTR);
            end
            jsu_pkg::MODE_STR, jsu_pkg::MODE_SBS:
            begin
                if (text_byte == jsu_pkg::CH_QUOTE || text_byte == jsu_pkg::CH_NUL) begin
                    pkt = single(8'h00, jsu_pkg::KIND_END);
                end else if (text_byte != jsu_pkg::CH_BSL) begin
                    pkt = single(text_byte, jsu_pkg::KIND_DATA);
                end
            end
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_SU:
            begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    pkt = single(8'h00, jsu_pkg::KIND_END);
                end else if (text_byte != jsu_pkg::CH_U) begin
                    pkt = single(escape_map(text_byte), jsu_pkg::KIND_DATA);
                end
            end
            jsu_pkg::MODE_HEX1:
            begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    pkt = single(8'h00, jsu_pkg::KIND_END);
                end else if (done && uc1 != 16'd0 && uc1[15:11] != 5'b11011) begin
                    pkt = utf1;
                end
            end
            jsu_pkg::MODE_HEX2:
            begin
                if (text_byte == jsu_pkg::CH_NUL) begin
                    pkt = single(8'h00, jsu_pkg::KIND_END);
                end else if (done && !bad_new && acc_new[15:10] == 6'b110111) begin
                    pkt = utf2;
                end
            end
            default:
            begin
                pkt = single(8'h00, jsu_pkg::KIND_NOTSTR);
            end
        endcase
    end

    assign push = accept && (pkt.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= jsu_pkg::MODE_WAIT;
            digit_count_reg <= 2'd0;
            code_accum_reg  <= 16'd0;
            high_half_reg   <= 10'd0;
            digit_bad_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
            code_accum_reg  <= code_accum_next;
            high_half_reg   <= high_half_next;
            digit_bad_reg   <= digit_bad_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/jsu_fifo.sv =====
// Small packet queue between the front end and the output serializer.
`default_nettype none
module jsu_fifo #(
    parameter int Depth = jsu_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::pkt_t wr_data,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::pkt_t      rd_data,
    output logic               rd_valid
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    jsu_pkg::pkt_t mem_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/jsu_back.sv =====
// Back end: sends each queued packet out one byte per transfer through an output register.
`default_nettype none
module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jsu_pkg::pkt_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic [1:0]         kind,
    output logic               last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_end;

    assign load   = head_valid && (!valid_reg || out_ready);
    assign at_end = ({1'b0, idx_reg} + 3'd1 == head.count);
    assign pop    = load && at_end;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (!valid_reg || out_ready) begin
            valid_next = head_valid;
        end
        if (load) begin
            byte_next = head.bytes[idx_reg];
            kind_next = head.kind;
            last_next = at_end;
            idx_next  = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

// ===== src/json_string_unescape_utf8.sv =====
// Path: the results of a source byte pass through the packet queue and then the output register.
// Throughput: one source byte per cycle in while the queue is not full, and one result
// byte per cycle out while out_ready is high; a source byte that yields several results
// holds the output register for one transfer per result, and the packet queue between
// front end and output register absorbs the difference. Reset: asynchronous, active low;
// it returns to waiting for an opening quote and empties the queue and the output register.
`default_nettype none
module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::QueueDepth
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic            last
);

    jsu_pkg::pkt_t front_pkt;
    jsu_pkg::pkt_t head_pkt;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .q_full    (q_full),
        .push      (q_push),
        .pkt       (front_pkt)
    );

    jsu_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  (front_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .rd_data  (head_pkt),
        .rd_valid (q_valid)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_pkt),
        .head_valid (q_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last)
    );

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != jsu_pkg::KIND_DATA |-> last)
        else $error("end or not-a-string result is not the last of its byte");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != jsu_pkg::KIND_DATA |-> out_byte == 8'h00)
        else $error("end or not-a-string result carries a nonzero byte");

    a_packet_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("multi-byte sequence broken after a transfer");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("packet queue popped while empty");

endmodule
`default_nettype wire

// ===== tb/tb_json_string_unescape_utf8.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`default_nettype none
module tb_json_string_unescape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 390;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIRECTED = 32;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_ONE
    } expect_src_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0]  b;
        expect_src_t src;
        logic [7:0]  xb;
        logic [1:0]  xk;
    } stim_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] text_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    jsu_pkg::mode_t st_mode;
    logic [1:0]     st_digits;
    logic [15:0]    st_acc;
    logic [9:0]     st_high;
    logic           st_bad;

    result_t    byte_results[$];
    result_t    decoded_fifo[$];
    result_t    want;
    logic [7:0] stream[$];

    int  errors = 0;
    int  cycles = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_strings = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    stim_t directed [NUM_DIRECTED] = '{
        '{8'h00,             EXP_ONE,   8'h00,           jsu_pkg::KIND_NOTSTR},
        '{8'hFF,             EXP_ONE,   8'h00,           jsu_pkg::KIND_NOTSTR},
        '{jsu_pkg::CH_QUOTE, EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{8'hFF,             EXP_ONE,   8'hFF,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_B,     EXP_ONE,   8'h08,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_F,     EXP_ONE,   8'h0C,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_N,     EXP_ONE,   8'h0A,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_R,     EXP_ONE,   8'h0D,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_T,     EXP_ONE,   8'h09,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_ONE,   jsu_pkg::CH_BSL, jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_U,     EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"D",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"8",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"3",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"D",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_BSL,   EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_U,     EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"d",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"e",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"0",               EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"0",               EXP_MODEL, 8'h00,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_QUOTE, EXP_ONE,   8'h00,           jsu_pkg::KIND_END},
        '{jsu_pkg::CH_QUOTE, EXP_NONE,  8'h00,           jsu_pkg::KIND_DATA},
        '{"A",               EXP_ONE,   8'h41,           jsu_pkg::KIND_DATA},
        '{jsu_pkg::CH_NUL,   EXP_ONE,   8'h00,           jsu_pkg::KIND_END}
    };

    json_string_unescape_utf8 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_hex(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic void put(logic [7:0] d, logic [1:0] k);
        byte_results.push_back('{d, k, 1'b0});
    endfunction

    function automatic void emit_utf8(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            put(cp[7:0], jsu_pkg::KIND_DATA);
        end
        else if (cp < 21'h800)
        begin
            put(8'hC0 | {3'b000, cp[10:6]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
        end
        else if (cp < 21'h10000)
        begin
            put(8'hE0 | {4'h0, cp[15:12]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
        end
        else
        begin
            put(8'hF0 | {5'd0, cp[20:18]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
            put({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
        end
    endfunction

    function automatic void close_string();
        put(8'h00, jsu_pkg::KIND_END);
        st_mode = jsu_pkg::MODE_WAIT;
    endfunction

    function automatic void start_digits(jsu_pkg::mode_t m);
        st_mode   = m;
        st_digits = 2'd0;
        st_acc    = 16'h0000;
        st_bad    = 1'b0;
    endfunction

    function automatic void string_char(logic [7:0] b);
        if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_NUL)
            close_string();
        else if (b == jsu_pkg::CH_BSL)
            st_mode = jsu_pkg::MODE_ESC;
        else
            put(b, jsu_pkg::KIND_DATA);
    endfunction

    function automatic void escape_char(logic [7:0] b);
        st_mode = jsu_pkg::MODE_STR;
        case (b)
            jsu_pkg::CH_NUL: close_string();
            jsu_pkg::CH_B:   put(8'h08, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_F:   put(8'h0C, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_N:   put(8'h0A, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_R:   put(8'h0D, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_T:   put(8'h09, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_U:   start_digits(jsu_pkg::MODE_HEX1);
            default:         put(b, jsu_pkg::KIND_DATA);
        endcase
    endfunction

    function automatic bit take_digit(logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= "0" && b <= "9")
            v = b - "0";
        else if (b >= "a" && b <= "f")
            v = b - "a" + 8'd10;
        else if (b >= "A" && b <= "F")
            v = b - "A" + 8'd10;
        else
            st_bad = 1'b1;
        st_acc = {st_acc[11:0], v[3:0]};
        if (st_digits == 2'd3)
            return 1'b1;
        st_digits = st_digits + 2'd1;
        return 1'b0;
    endfunction

    function automatic void unescape_byte(logic [7:0] b);
        logic [15:0] cp;
        byte_results.delete();
        case (st_mode)
            jsu_pkg::MODE_WAIT:
                if (b == jsu_pkg::CH_QUOTE)
                    st_mode = jsu_pkg::MODE_STR;
                else
                    put(8'h00, jsu_pkg::KIND_NOTSTR);
            jsu_pkg::MODE_STR:
                string_char(b);
            jsu_pkg::MODE_ESC:
                escape_char(b);
            jsu_pkg::MODE_HEX1:
                if (b == jsu_pkg::CH_NUL)
                    close_string();
                else if (take_digit(b))
                begin
                    cp = st_bad ? 16'h0000 : st_acc;
                    st_mode = jsu_pkg::MODE_STR;
                    if (cp != 16'h0000 && !(cp >= LOW_FIRST && cp <= LOW_LAST))
                    begin
                        if (cp >= HIGH_FIRST && cp <= HIGH_LAST)
                        begin
                            st_high = cp[9:0];
                            st_mode = jsu_pkg::MODE_SBS;
                        end
                        else
                            emit_utf8({5'd0, cp});
                    end
                end
            jsu_pkg::MODE_SBS:
                if (b == jsu_pkg::CH_BSL)
                    st_mode = jsu_pkg::MODE_SU;
                else
                begin
                    st_mode = jsu_pkg::MODE_STR;
                    string_char(b);
                end
            jsu_pkg::MODE_SU:
                if (b == jsu_pkg::CH_U)
                    start_digits(jsu_pkg::MODE_HEX2);
                else
                    escape_char(b);
            jsu_pkg::MODE_HEX2:
                if (b == jsu_pkg::CH_NUL)
                    close_string();
                else if (take_digit(b))
                begin
                    st_mode = jsu_pkg::MODE_STR;
                    if (!st_bad && st_acc >= LOW_FIRST && st_acc <= LOW_LAST)
                        emit_utf8(21'h10000 + {1'b0, st_high, st_acc[9:0]});
                end
            default:
            begin
                st_mode = jsu_pkg::MODE_WAIT;
                put(8'h00, jsu_pkg::KIND_NOTSTR);
            end
        endcase
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return "0" + {4'h0, v};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_hex(c));
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0: c = jsu_pkg::CH_B;
            1: c = jsu_pkg::CH_F;
            2: c = jsu_pkg::CH_N;
            3: c = jsu_pkg::CH_R;
            4: c = jsu_pkg::CH_T;
            default:
                do
                    c = 8'($urandom_range(1, 255));
                while (c == jsu_pkg::CH_U);
        endcase
        return c;
    endfunction

    function automatic void add_u(logic [15:0] v);
        stream.push_back(jsu_pkg::CH_BSL);
        stream.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--)
            stream.push_back(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic void spoil_digit();
        stream[stream.size() - 1 - $urandom_range(0, 3)] = non_hex();
    endfunction

    function automatic logic [15:0] high_value();
        return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
    endfunction

    // Appends one piece of string content; returns 1 when that piece closed the string.
    function automatic bit add_fragment();
        int          pick;
        logic [15:0] v;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            stream.push_back(plain_char());
        else if (pick < 50)
        begin
            stream.push_back(jsu_pkg::CH_BSL);
            stream.push_back(escape_letter());
        end
        else if (pick < 65)
        begin
            case ($urandom_range(0, 4))
                0: v = 16'($urandom_range(16'h0001, 16'h007F));
                1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                2: v = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                            : 16'($urandom_range(16'hE000, 16'hFFFF));
                3: v = 16'h0000;
                default: v = 16'($urandom_range(LOW_FIRST, LOW_LAST));
            endcase
            add_u(v);
        end
        else if (pick < 80)
        begin
            add_u(high_value());
            add_u(16'($urandom_range(LOW_FIRST, LOW_LAST)));
        end
        else if (pick < 85)
        begin
            add_u(high_value());
            do
                c = 8'($urandom_range(1, 255));
            while (c == jsu_pkg::CH_BSL);
            stream.push_back(c);
            return c == jsu_pkg::CH_QUOTE;
        end
        else if (pick < 89)
        begin
            add_u(high_value());
            stream.push_back(jsu_pkg::CH_BSL);
            stream.push_back(escape_letter());
        end
        else if (pick < 93)
        begin
            add_u(high_value());
            if ($urandom_range(0, 1))
            begin
                do
                    v = 16'($urandom_range(0, 16'hFFFF));
                while (v >= LOW_FIRST && v <= LOW_LAST);
                add_u(v);
            end
            else
            begin
                add_u(16'($urandom_range(LOW_FIRST, LOW_LAST)));
                spoil_digit();
            end
        end
        else if (pick < 97)
        begin
            add_u(16'($urandom_range(0, 16'hFFFF)));
            spoil_digit();
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                stream.push_back(jsu_pkg::CH_BSL);
            else
            begin
                if ($urandom_range(0, 1))
                    add_u(high_value());
                stream.push_back(jsu_pkg::CH_BSL);
                stream.push_back(jsu_pkg::CH_U);
                repeat ($urandom_range(0, 3))
                    stream.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            stream.push_back(jsu_pkg::CH_NUL);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void build_stream();
        bit         closed;
        logic [7:0] c;
        while (stream.size() < RANDOM_BYTES)
        begin
            repeat ($urandom_range(0, 3))
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == jsu_pkg::CH_QUOTE);
                stream.push_back(c);
            end
            stream.push_back(jsu_pkg::CH_QUOTE);
            closed = 1'b0;
            for (int i = $urandom_range(0, 8); i > 0 && !closed; i--)
                closed = add_fragment();
            if (!closed)
                stream.push_back($urandom_range(0, 5) == 0 ? jsu_pkg::CH_NUL
                                                           : jsu_pkg::CH_QUOTE);
            n_strings++;
        end
    endfunction

    task automatic send(stim_t s);
        int gap;
        if (n_sent % 50 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= s.b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
        unescape_byte(s.b);
        case (s.src)
            EXP_MODEL: decoded_fifo = {decoded_fifo, byte_results};
            EXP_ONE:   decoded_fifo.push_back('{s.xb, s.xk, 1'b1});
            default:   ;
        endcase
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_fifo.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        text_byte = 8'h00;
        out_ready = 1'b0;
        st_mode   = jsu_pkg::MODE_WAIT;
        st_digits = 2'd0;
        st_acc    = 16'h0000;
        st_high   = 10'h000;
        st_bad    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send(directed[i]);
        hold_until_drained();
        build_stream();
        foreach (stream[i])
        begin
            if (i == stream.size() / 2)
                hold_until_drained();
            send('{stream[i], EXP_MODEL, 8'h00, jsu_pkg::KIND_DATA});
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Streamed %0d source bytes (%0d directed, %0d random strings with escapes,",
                 n_sent, NUM_DIRECTED, n_strings);
        $display("surrogate pairs and malformed sequences); %0d result transfers compared.",
                 n_checked);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_checked++;
            if (decoded_fifo.size() == 0)
            begin
                $error("unexpected result: out_byte=%02h kind=%0d last=%0b",
                       out_byte, kind, last);
                errors++;
            end
            else
            begin
                want = decoded_fifo.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    errors++;
                end
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 9);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, decoded_fifo.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
`default_nettype wire
